@@ rtl/adaptive_step_size_controller_core_macros.svh @@
// Assertion macros shared by the step-size controller RTL
`ifndef ADAPTIVE_STEP_SIZE_CONTROLLER_CORE_MACROS_SVH
`define ADAPTIVE_STEP_SIZE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/assc_pkg.sv @@
// Package: widths, codes and register map of the step-size controller
`timescale 1ns / 1ps
package assc_pkg;

    localparam int STEP_WIDTH = 48;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int LOG_W      = 22;
    localparam int PROD_W     = 80;

    localparam logic [STEP_WIDTH-1:0] STEP_MASK   = {STEP_WIDTH{1'b1}};
    localparam logic [STEP_WIDTH-1:0] TOL_RESET   = STEP_WIDTH'(64'd4295);
    localparam logic [STEP_WIDTH-1:0] START_RESET = STEP_WIDTH'(64'd42949673);
    localparam logic [15:0]           SAFETY_RESET = 16'd58982;
    localparam logic [19:0]           FLOOR_RESET  = 20'd0;
    localparam logic [19:0]           CAP_RESET    = 20'd327680;
    localparam logic [3:0]            ORDER_RESET  = 4'd4;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_ERROR = 1'b1;

    typedef enum logic [1:0] {
        STAT_TRIAL     = 2'd0,
        STAT_ACCEPT    = 2'd1,
        STAT_RETRY     = 2'd2,
        STAT_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_TOLERANCE = 3'd0,
        REG_START     = 3'd1,
        REG_SAFETY    = 3'd2,
        REG_FLOOR     = 3'd3,
        REG_CAP       = 3'd4,
        REG_ORDER     = 3'd5
    } reg_index_t;

endpackage

@@ rtl/assc_in_if.sv @@
// Input item channel of the step-size controller
`timescale 1ns / 1ps
interface assc_in_if;
    import assc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic                         at_start;
    logic                         time_limited;
    logic signed [STEP_WIDTH-1:0] error_value;
    logic                         last_error;

    modport source (output valid, command, at_start, time_limited, error_value, last_error,
                    input ready);
    modport sink (input valid, command, at_start, time_limited, error_value, last_error,
                  output ready);
endinterface

@@ rtl/assc_out_if.sv @@
// Result item channel of the step-size controller
`timescale 1ns / 1ps
interface assc_out_if;
    import assc_pkg::*;
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [STEP_WIDTH-1:0] step_size;

    modport source (output valid, status, step_size, input ready);
    modport sink (input valid, status, step_size, output ready);
endinterface

@@ rtl/adaptive_step_size_controller_core.sv @@
// Top level: adaptive step-size controller with a shared multiply/sqrt sequencer
//
//  channel | dir | handshake      | payload
//  cmd     | in  | valid/ready    | command, at_start, time_limited, error_value, last_error
//  rsp     | out | valid/ready    | status, step_size
//  apb     | in  | psel/penable   | paddr, pwdata, pwrite -> prdata, pready
//
// Begin, non-final error and time-limited final error items are handled in ST_IDLE.
// A final error item of a step that is not time-limited runs two log2 passes (normalize
// shifts, then 16 serial squarings each), a serial divide, 16 serial square roots and three
// serial multiplies, with cmd.ready low meanwhile.
// Reset (rst_n low) loads register defaults and clears control state at once.
// A result waits in the output register; the next item is taken once it is free or leaving.
`timescale 1ns / 1ps
`include "adaptive_step_size_controller_core_macros.svh"
module adaptive_step_size_controller_core (
    input  logic                             clk,
    input  logic                             rst_n,
    assc_in_if.sink                          cmd,
    assc_out_if.source                       rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [assc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [assc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [assc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import assc_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_NORM     = 13'b0000000000010,
        ST_MUL_SQ   = 13'b0000000000100,
        ST_SQ_STEP  = 13'b0000000001000,
        ST_DIV      = 13'b0000000010000,
        ST_EXP_LOAD = 13'b0000000100000,
        ST_SQRT     = 13'b0000001000000,
        ST_MUL_SH   = 13'b0000010000000,
        ST_SH_DONE  = 13'b0000100000000,
        ST_MUL_Y    = 13'b0001000000000,
        ST_Y_DONE   = 13'b0010000000000,
        ST_MUL_LIM  = 13'b0100000000000,
        ST_FIN      = 13'b1000000000000
    } state_t;

    function automatic logic [STEP_WIDTH-1:0] mul_shift(input logic [PROD_W-1:0] p,
                                                        input logic signed [8:0] sh);
        logic [127:0] w;
        logic [8:0]   ls;
        begin
            ls = 9'd0 - sh;
            if (!sh[8])
                w = {48'd0, p} >> sh[7:0];
            else
                w = {48'd0, p} << ls[7:0];
            mul_shift = (|w[127:STEP_WIDTH]) ? STEP_MASK : w[STEP_WIDTH-1:0];
        end
    endfunction

    state_t                state_reg, state_next;

    logic [STEP_WIDTH-1:0] tol_reg, start_reg;
    logic [15:0]           safety_reg;
    logic [19:0]           floor_reg, cap_reg;
    logic [3:0]            order_reg;

    logic [STEP_WIDTH-1:0] stored_reg, stored_next;
    logic [STEP_WIDTH-1:0] trial_reg, trial_next;
    logic [STEP_WIDTH-1:0] largest_reg, largest_next;
    logic                  forced_reg, forced_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  reject_reg, reject_next;
    logic                  which_reg, which_next;

    status_t               out_status_reg, out_status_next;
    logic [STEP_WIDTH-1:0] out_step_reg, out_step_next;
    logic [STEP_WIDTH-1:0] xs_reg, xs_next;
    logic [5:0]            k_reg, k_next;
    logic [15:0]           frac_reg, frac_next;
    logic [3:0]            sq_cnt_reg, sq_cnt_next;
    logic [LOG_W-1:0]      log_t_reg, log_t_next;
    logic [LOG_W-1:0]      dnum_reg, dnum_next;
    logic [4:0]            drem_reg, drem_next;
    logic [4:0]            div_cnt_reg, div_cnt_next;
    logic                  neg_reg, neg_next;
    logic signed [7:0]     n_reg, n_next;
    logic [15:0]           f_reg, f_next;
    logic [31:0]           y_reg, y_next;
    logic [3:0]            exp_cnt_reg, exp_cnt_next;
    logic [63:0]           sq_rem_reg, sq_rem_next;
    logic [63:0]           sq_res_reg, sq_res_next;
    logic [63:0]           sq_bit_reg, sq_bit_next;
    logic [4:0]            sqrt_cnt_reg, sqrt_cnt_next;
    logic [PROD_W-1:0]     mul_a_reg, mul_a_next;
    logic [31:0]           mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]     mul_acc_reg, mul_acc_next;
    logic [4:0]            mul_cnt_reg, mul_cnt_next;
    logic [STEP_WIDTH-1:0] c_reg, c_next;

    logic                  in_fire, out_free, cfg_wr;
    logic [STEP_WIDTH-1:0] err_mag, err_max, tol_one, delta_one;
    logic [31:0]           sq_prod;
    logic [30:0]           m_new;
    logic [15:0]           frac_new;
    logic [LOG_W-1:0]      log_new;
    logic signed [LOG_W:0] d_diff;
    logic [LOG_W:0]        d_abs;
    logic [4:0]            q_div;
    logic [5:0]            d_trial;
    logic [LOG_W:0]        q_mag;
    logic [23:0]           e_val;
    logic [63:0]           rad, sq_sum;
    logic signed [8:0]     y_shift;
    logic [STEP_WIDTH-1:0] lim_val, pick;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = cmd.valid && cmd.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.step_size = out_step_reg;

    always_comb
    begin
        unique case (reg_index_t'(paddr[5:3]))
            REG_TOLERANCE: prdata = CFG_DATA_W'(tol_reg);
            REG_START:     prdata = CFG_DATA_W'(start_reg);
            REG_SAFETY:    prdata = CFG_DATA_W'(safety_reg);
            REG_FLOOR:     prdata = CFG_DATA_W'(floor_reg);
            REG_CAP:       prdata = CFG_DATA_W'(cap_reg);
            REG_ORDER:     prdata = CFG_DATA_W'(order_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            start_reg  <= START_RESET;
            safety_reg <= SAFETY_RESET;
            floor_reg  <= FLOOR_RESET;
            cap_reg    <= CAP_RESET;
            order_reg  <= ORDER_RESET;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0)
        begin
            unique case (reg_index_t'(paddr[5:3]))
                REG_TOLERANCE: tol_reg    <= pwdata[STEP_WIDTH-1:0];
                REG_START:     start_reg  <= pwdata[STEP_WIDTH-1:0];
                REG_SAFETY:    safety_reg <= pwdata[15:0];
                REG_FLOOR:     floor_reg  <= pwdata[19:0];
                REG_CAP:       cap_reg    <= pwdata[19:0];
                REG_ORDER:     order_reg  <= pwdata[3:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        err_mag   = cmd.error_value[STEP_WIDTH-1] ? (STEP_WIDTH'(0) - cmd.error_value)
                                                  : cmd.error_value;
        err_max   = (err_mag > largest_reg) ? err_mag : largest_reg;
        tol_one   = (tol_reg == '0) ? STEP_WIDTH'(1) : tol_reg;
        delta_one = (largest_reg == '0) ? STEP_WIDTH'(1) : largest_reg;

        sq_prod   = mul_acc_reg[61:30];
        m_new     = sq_prod[31] ? sq_prod[31:1] : sq_prod[30:0];
        frac_new  = {frac_reg[14:0], sq_prod[31]};
        log_new   = {k_reg, frac_new};
        d_diff    = $signed({1'b0, log_t_reg}) - $signed({1'b0, log_new});
        d_abs     = d_diff[LOG_W] ? (23'd0 - d_diff) : d_diff;

        q_div     = {1'b0, order_reg} + 5'd1;
        d_trial   = {drem_reg, dnum_reg[LOG_W-1]};
        q_mag     = {1'b0, dnum_reg} + {22'd0, (neg_reg && drem_reg != 5'd0)};
        e_val     = neg_reg ? (24'd0 - {1'b0, q_mag}) : {1'b0, q_mag};

        rad       = (f_reg[exp_cnt_reg] ? {31'd0, y_reg, 1'b0} : {32'd0, y_reg}) << 30;
        sq_sum    = sq_res_reg + sq_bit_reg;
        y_shift   = 9'sd30 - 9'(n_reg);
        lim_val   = mul_shift(mul_acc_reg, 9'sd16);
        pick      = '0;

        state_next      = state_reg;
        stored_next     = stored_reg;
        trial_next      = trial_reg;
        largest_next    = largest_reg;
        forced_next     = forced_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        reject_next     = reject_reg;
        which_next      = which_reg;
        out_status_next = out_status_reg;
        out_step_next   = out_step_reg;
        xs_next         = xs_reg;
        k_next          = k_reg;
        frac_next       = frac_reg;
        sq_cnt_next     = sq_cnt_reg;
        log_t_next      = log_t_reg;
        dnum_next       = dnum_reg;
        drem_next       = drem_reg;
        div_cnt_next    = div_cnt_reg;
        neg_next        = neg_reg;
        n_next          = n_reg;
        f_next          = f_reg;
        y_next          = y_reg;
        exp_cnt_next    = exp_cnt_reg;
        sq_rem_next     = sq_rem_reg;
        sq_res_next     = sq_res_reg;
        sq_bit_next     = sq_bit_reg;
        sqrt_cnt_next   = sqrt_cnt_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        mul_acc_next    = mul_acc_reg;
        mul_cnt_next    = mul_cnt_reg;
        c_next          = c_reg;

        if (state_reg == ST_MUL_SQ || state_reg == ST_MUL_SH || state_reg == ST_MUL_Y ||
            state_reg == ST_MUL_LIM)
        begin
            mul_acc_next = mul_acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);
            mul_a_next   = mul_a_reg << 1;
            mul_b_next   = mul_b_reg >> 1;
            mul_cnt_next = mul_cnt_reg + 5'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd.command == CMD_BEGIN)
                    begin
                        trial_next      = cmd.at_start ? start_reg : stored_reg;
                        stored_next     = trial_next;
                        forced_next     = cmd.time_limited;
                        largest_next    = '0;
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_TRIAL;
                        out_step_next   = trial_next;
                    end
                    else if (!cmd.last_error)
                        largest_next = err_max;
                    else if (forced_reg)
                    begin
                        largest_next    = '0;
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_ACCEPT;
                        out_step_next   = stored_reg;
                    end
                    else
                    begin
                        largest_next = err_max;
                        reject_next  = err_max > tol_reg;
                        xs_next      = tol_one;
                        k_next       = 6'd47;
                        which_next   = 1'b0;
                        state_next   = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (xs_reg[STEP_WIDTH-1])
                begin
                    frac_next    = '0;
                    sq_cnt_next  = '0;
                    mul_a_next   = PROD_W'(xs_reg[STEP_WIDTH-1 -: 31]);
                    mul_b_next   = 32'(xs_reg[STEP_WIDTH-1 -: 31]);
                    mul_acc_next = '0;
                    mul_cnt_next = '0;
                    state_next   = ST_MUL_SQ;
                end
                else
                begin
                    xs_next = xs_reg << 1;
                    k_next  = k_reg - 6'd1;
                end
            end
            ST_MUL_SQ:
            begin
                if (mul_cnt_reg == 5'd31)
                    state_next = ST_SQ_STEP;
            end
            ST_SQ_STEP:
            begin
                frac_next   = frac_new;
                sq_cnt_next = sq_cnt_reg + 4'd1;
                if (sq_cnt_reg == 4'd15)
                begin
                    if (!which_reg)
                    begin
                        log_t_next = log_new;
                        xs_next    = delta_one;
                        k_next     = 6'd47;
                        which_next = 1'b1;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        neg_next     = d_diff[LOG_W];
                        dnum_next    = d_abs[LOG_W-1:0];
                        drem_next    = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
                else
                begin
                    mul_a_next   = PROD_W'(m_new);
                    mul_b_next   = 32'(m_new);
                    mul_acc_next = '0;
                    mul_cnt_next = '0;
                    state_next   = ST_MUL_SQ;
                end
            end
            ST_DIV:
            begin
                if (d_trial >= {1'b0, q_div})
                begin
                    drem_next = 5'(d_trial - {1'b0, q_div});
                    dnum_next = {dnum_reg[LOG_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = d_trial[4:0];
                    dnum_next = {dnum_reg[LOG_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(LOG_W - 1))
                    state_next = ST_EXP_LOAD;
                y_next       = 32'd1 << 30;
                exp_cnt_next = '0;
            end
            ST_EXP_LOAD:
            begin
                if (exp_cnt_reg == 4'd0)
                begin
                    n_next = e_val[23:16];
                    f_next = e_val[15:0];
                end
                sq_rem_next   = (exp_cnt_reg == 4'd0)
                              ? ((e_val[0] ? {31'd0, y_reg, 1'b0} : {32'd0, y_reg}) << 30)
                              : rad;
                sq_res_next   = '0;
                sq_bit_next   = 64'd1 << 62;
                sqrt_cnt_next = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sq_rem_reg >= sq_sum)
                begin
                    sq_rem_next = sq_rem_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next   = sq_bit_reg >> 2;
                sqrt_cnt_next = sqrt_cnt_reg + 5'd1;
                if (sqrt_cnt_reg == 5'd31)
                begin
                    y_next       = sq_res_next[31:0];
                    exp_cnt_next = exp_cnt_reg + 4'd1;
                    if (exp_cnt_reg == 4'd15)
                    begin
                        mul_a_next   = PROD_W'(trial_reg);
                        mul_b_next   = 32'(safety_reg);
                        mul_acc_next = '0;
                        mul_cnt_next = '0;
                        state_next   = ST_MUL_SH;
                    end
                    else
                        state_next = ST_EXP_LOAD;
                end
            end
            ST_MUL_SH:
            begin
                if (mul_cnt_reg == 5'd31)
                    state_next = ST_SH_DONE;
            end
            ST_SH_DONE:
            begin
                mul_a_next   = PROD_W'(lim_val);
                mul_b_next   = y_reg;
                mul_acc_next = '0;
                mul_cnt_next = '0;
                state_next   = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                if (mul_cnt_reg == 5'd31)
                    state_next = ST_Y_DONE;
            end
            ST_Y_DONE:
            begin
                c_next       = mul_shift(mul_acc_reg, y_shift);
                mul_a_next   = PROD_W'(trial_reg);
                mul_b_next   = 32'(reject_reg ? floor_reg : cap_reg);
                mul_acc_next = '0;
                mul_cnt_next = '0;
                state_next   = ST_MUL_LIM;
            end
            ST_MUL_LIM:
            begin
                if (mul_cnt_reg == 5'd31)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (reject_reg)
                    begin
                        pick = (c_reg > lim_val) ? c_reg : lim_val;
                        if (pick == '0)
                            out_status_next = STAT_UNDERFLOW;
                        else
                        begin
                            out_status_next = STAT_RETRY;
                            trial_next      = pick;
                        end
                    end
                    else
                    begin
                        pick = (c_reg < lim_val) ? c_reg : lim_val;
                        if (pick < trial_reg)
                            pick = trial_reg;
                        out_status_next = STAT_ACCEPT;
                        stored_next     = pick;
                    end
                    out_step_next  = pick;
                    out_valid_next = 1'b1;
                    largest_next   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stored_reg    <= START_RESET;
            trial_reg     <= '0;
            largest_reg   <= '0;
            forced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            trial_reg     <= trial_next;
            largest_reg   <= largest_next;
            forced_reg    <= forced_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reject_reg     <= reject_next;
        which_reg      <= which_next;
        out_status_reg <= out_status_next;
        out_step_reg   <= out_step_next;
        xs_reg         <= xs_next;
        k_reg          <= k_next;
        frac_reg       <= frac_next;
        sq_cnt_reg     <= sq_cnt_next;
        log_t_reg      <= log_t_next;
        dnum_reg       <= dnum_next;
        drem_reg       <= drem_next;
        div_cnt_reg    <= div_cnt_next;
        neg_reg        <= neg_next;
        n_reg          <= n_next;
        f_reg          <= f_next;
        y_reg          <= y_next;
        exp_cnt_reg    <= exp_cnt_next;
        sq_rem_reg     <= sq_rem_next;
        sq_res_reg     <= sq_res_next;
        sq_bit_reg     <= sq_bit_next;
        sqrt_cnt_reg   <= sqrt_cnt_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        mul_acc_reg    <= mul_acc_next;
        mul_cnt_reg    <= mul_cnt_next;
        c_reg          <= c_next;
    end

    `ASSC_ASSERT_NXT(a_begin_gives_trial, in_fire && cmd.command == CMD_BEGIN, rsp.valid && rsp.status == STAT_TRIAL, "begin item did not yield a trial result")
    `ASSC_ASSERT_IMP(a_busy_not_ready, state_reg != ST_IDLE, !cmd.ready, "input taken while sequencer busy")
    `ASSC_ASSERT_IMP(a_underflow_zero, rsp.valid && rsp.status == STAT_UNDERFLOW, rsp.step_size == '0, "underflow result with nonzero step")

endmodule

@@ verif/tb_adaptive_step_size_controller_core.sv @@
// Testbench for the adaptive step-size controller: directed table, then random trial sequences
`timescale 1ns / 1ps
module tb_adaptive_step_size_controller_core;
    import assc_pkg::*;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        reg_index_t            ridx;
        logic [63:0]           value;
        logic                  command;
        logic                  at_start;
        logic                  time_limited;
        logic [STEP_WIDTH-1:0] error_value;
        logic                  last_error;
        logic                  typed;
        status_t               exp_status;
        logic [STEP_WIDTH-1:0] exp_step;
    } stim_row_t;

    typedef struct {
        status_t               status;
        logic [STEP_WIDTH-1:0] step_size;
    } step_result_t;

    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    assc_in_if  cmd_if ();
    assc_out_if rsp_if ();

    adaptive_step_size_controller_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [STEP_WIDTH-1:0] m_tolerance, m_start, m_stored, m_trial, m_largest;
    logic [15:0] m_safety;
    logic [19:0] m_floor, m_cap;
    logic [3:0]  m_order;
    logic        m_forced;

    step_result_t step_q[$];
    stim_row_t    rows[$];
    int  fail_cnt = 0;
    int  accepted_cnt = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    bit  held = 0;
    logic                  cur_typed;
    status_t               cur_status;
    logic [STEP_WIDTH-1:0] cur_step;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
        logic [127:0] p;
        logic [127:0] r;
        int ls;
        p = {64'd0, a} * {64'd0, b};
        if (sh >= 128) return 64'd0;
        if (sh >= 0) begin
            r = p >> sh;
            return (r > {80'd0, STEP_MASK}) ? {16'd0, STEP_MASK} : r[63:0];
        end
        ls = -sh;
        if (p == 0) return 64'd0;
        if (p[127:64] != 0 || ls >= 64 || p[63:0] > ({16'd0, STEP_MASK} >> ls))
            return {16'd0, STEP_MASK};
        return p[63:0] << ls;
    endfunction

    function automatic longint log2_q16(input logic [63:0] x);
        int k;
        logic [63:0] m;
        longint frac;
        k = 63;
        frac = 0;
        if (x == 0) x = 1;
        while (x[k] == 1'b0) k--;
        m = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) << 16) | frac;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] scaled_root(input logic [63:0] h, input logic [63:0] delta);
        longint d, q, e, n, f;
        logic [63:0] y;
        logic [63:0] sh_h;
        d = log2_q16((m_tolerance != 0) ? {16'd0, m_tolerance} : 64'd1)
            - log2_q16((delta != 0) ? delta : 64'd1);
        q = longint'(m_order) + 1;
        e = (d >= 0) ? d / q : -((-d + q - 1) / q);
        n = (e >= 0) ? e / 65536 : -((-e + 65535) / 65536);
        f = e - n * 65536;
        y = 64'd1 << 30;
        for (int i = 0; i < 16; i++)
            y = floor_sqrt((y << ((f >> i) & 1)) << 30);
        sh_h = mul_sat(h, {48'd0, m_safety}, 16);
        return mul_sat(sh_h, y, int'(30 - n));
    endfunction

    function automatic bit predict_step(input logic command, input logic at_start,
                                        input logic time_limited,
                                        input logic [STEP_WIDTH-1:0] error_value,
                                        input logic last_error, output step_result_t res);
        logic [STEP_WIDTH-1:0] mag;
        logic [63:0] h, c, lim, r;
        if (command == CMD_BEGIN) begin
            if (at_start) m_stored = m_start;
            m_trial = m_stored;
            m_forced = time_limited;
            m_largest = 0;
            res.status = STAT_TRIAL;
            res.step_size = m_trial;
            return 1'b1;
        end
        mag = error_value[STEP_WIDTH-1] ? -error_value : error_value;
        if (mag > m_largest) m_largest = mag;
        if (!last_error) return 1'b0;
        h = {16'd0, m_trial};
        if (m_forced) begin
            res.status = STAT_ACCEPT;
            r = {16'd0, m_stored};
        end else if (m_largest > m_tolerance) begin
            c = scaled_root(h, {16'd0, m_largest});
            lim = mul_sat(h, {44'd0, m_floor}, 16);
            r = (c > lim) ? c : lim;
            if (r == 0) begin
                res.status = STAT_UNDERFLOW;
            end else begin
                res.status = STAT_RETRY;
                m_trial = r[STEP_WIDTH-1:0];
            end
        end else begin
            c = scaled_root(h, {16'd0, m_largest});
            lim = mul_sat(h, {44'd0, m_cap}, 16);
            r = (c < lim) ? c : lim;
            if (r < h) r = h;
            res.status = STAT_ACCEPT;
            m_stored = r[STEP_WIDTH-1:0];
        end
        m_largest = 0;
        res.step_size = r[STEP_WIDTH-1:0];
        return 1'b1;
    endfunction

    always @(posedge clk) begin
        step_result_t res;
        if (rst_n && cmd_if.valid && cmd_if.ready) begin
            accepted_cnt <= accepted_cnt + 1;
            if (predict_step(cmd_if.command, cmd_if.at_start, cmd_if.time_limited,
                             cmd_if.error_value, cmd_if.last_error, res)) begin
                if (cur_typed) begin
                    res.status = cur_status;
                    res.step_size = cur_step;
                end
                step_q.push_back(res);
            end
        end
    end

    always @(posedge clk) begin
        step_result_t exp_res;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (step_q.size() == 0) begin
                $error("unexpected result: status %0d step_size %0h",
                       rsp_if.status, rsp_if.step_size);
                fail_cnt++;
            end else begin
                exp_res = step_q.pop_front();
                if (rsp_if.status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, rsp_if.status);
                    fail_cnt++;
                end
                if (rsp_if.step_size !== exp_res.step_size) begin
                    $error("step_size: expected %0h, actual %0h",
                           exp_res.step_size, rsp_if.step_size);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!held && accepted_cnt >= 150) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input stim_row_t row);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= row.command;
        cmd_if.at_start     <= row.at_start;
        cmd_if.time_limited <= row.time_limited;
        cmd_if.error_value  <= row.error_value;
        cmd_if.last_error   <= row.last_error;
        cur_typed           <= row.typed;
        cur_status          <= row.exp_status;
        cur_step            <= row.exp_step;
        do @(posedge clk); while (!cmd_if.ready);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (step_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t ridx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(ridx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (ridx)
            REG_TOLERANCE: m_tolerance = value[STEP_WIDTH-1:0];
            REG_START:     m_start = value[STEP_WIDTH-1:0];
            REG_SAFETY:    m_safety = value[15:0];
            REG_FLOOR:     m_floor = value[19:0];
            REG_CAP:       m_cap = value[19:0];
            REG_ORDER:     m_order = value[3:0];
            default: ;
        endcase
    endtask

    function automatic stim_row_t begin_row(input logic at_start, input logic time_limited,
                                           input logic typed, input status_t st,
                                           input logic [STEP_WIDTH-1:0] step);
        stim_row_t row;
        row = '{kind: ROW_ITEM, ridx: REG_TOLERANCE, value: 0, command: CMD_BEGIN,
                at_start: at_start, time_limited: time_limited, error_value: 0,
                last_error: 0, typed: typed, exp_status: st, exp_step: step};
        return row;
    endfunction

    function automatic stim_row_t error_row(input logic [STEP_WIDTH-1:0] err, input logic last,
                                            input logic typed, input status_t st,
                                            input logic [STEP_WIDTH-1:0] step);
        stim_row_t row;
        row = begin_row(0, 0, typed, st, step);
        row.command = CMD_ERROR;
        row.error_value = err;
        row.last_error = last;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input reg_index_t ridx, input logic [63:0] value);
        stim_row_t row;
        row = begin_row(0, 0, 0, STAT_TRIAL, 0);
        row.kind = ROW_CFG;
        row.ridx = ridx;
        row.value = value;
        return row;
    endfunction

    function automatic logic [STEP_WIDTH-1:0] rand_error();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        raw = raw >> $urandom_range(16, 63);
        if ($urandom_range(0, 15) == 0) raw = {$urandom, $urandom};
        return $urandom_range(0, 1) ? -raw[STEP_WIDTH-1:0] : raw[STEP_WIDTH-1:0];
    endfunction

    function automatic logic [63:0] pick(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] raw;
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: begin
                raw = {$urandom, $urandom} >> $urandom_range(0, 63);
                return (raw < lo) ? lo : (raw > hi) ? hi : raw;
            end
        endcase
    endfunction

    localparam logic [STEP_WIDTH-1:0] MOST_NEG = {1'b1, {(STEP_WIDTH-1){1'b0}}};
    localparam logic [STEP_WIDTH-1:0] MOST_POS = {1'b0, {(STEP_WIDTH-1){1'b1}}};

    initial begin
        int n_err;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_BEGIN;
        cmd_if.at_start = 1'b0;
        cmd_if.time_limited = 1'b0;
        cmd_if.error_value = '0;
        cmd_if.last_error = 1'b0;
        cur_typed = 1'b0;
        cur_status = STAT_TRIAL;
        cur_step = '0;
        m_tolerance = TOL_RESET;
        m_start = START_RESET;
        m_safety = SAFETY_RESET;
        m_floor = FLOOR_RESET;
        m_cap = CAP_RESET;
        m_order = ORDER_RESET;
        m_stored = START_RESET;
        m_trial = '0;
        m_largest = '0;
        m_forced = 1'b0;

        rows.push_back(error_row(48'd12345, 1, 0, STAT_TRIAL, 0));
        rows.push_back(begin_row(0, 0, 1, STAT_TRIAL, START_RESET));
        rows.push_back(error_row(48'd0, 1, 0, STAT_TRIAL, 0));
        rows.push_back(begin_row(1, 0, 1, STAT_TRIAL, START_RESET));
        rows.push_back(error_row(MOST_POS, 0, 0, STAT_TRIAL, 0));
        rows.push_back(error_row(MOST_NEG, 1, 0, STAT_TRIAL, 0));
        rows.push_back(begin_row(0, 1, 0, STAT_TRIAL, 0));
        rows.push_back(error_row(48'd5, 1, 0, STAT_TRIAL, 0));
        rows.push_back(error_row(48'd3, 1, 0, STAT_TRIAL, 0));
        rows.push_back(cfg_row(REG_START, 64'd1));
        rows.push_back(begin_row(1, 0, 1, STAT_TRIAL, 48'd1));
        rows.push_back(error_row(MOST_NEG, 1, 1, STAT_UNDERFLOW, 48'd0));
        rows.push_back(cfg_row(REG_ORDER, 64'd15));
        rows.push_back(cfg_row(REG_FLOOR, 64'hFFFFF));
        rows.push_back(cfg_row(REG_CAP, 64'hFFFFF));
        rows.push_back(cfg_row(REG_SAFETY, 64'hFFFF));
        rows.push_back(cfg_row(REG_TOLERANCE, {16'd0, STEP_MASK}));
        rows.push_back(cfg_row(REG_START, {16'd0, STEP_MASK}));
        rows.push_back(begin_row(1, 0, 1, STAT_TRIAL, STEP_MASK));
        rows.push_back(error_row(MOST_NEG, 1, 0, STAT_TRIAL, 0));
        rows.push_back(cfg_row(REG_TOLERANCE, 64'd1));
        rows.push_back(cfg_row(REG_SAFETY, 64'd0));
        rows.push_back(cfg_row(REG_CAP, 64'd65536));
        rows.push_back(cfg_row(REG_ORDER, 64'd1));
        rows.push_back(begin_row(1, 0, 1, STAT_TRIAL, STEP_MASK));
        rows.push_back(error_row(48'd1, 1, 0, STAT_TRIAL, 0));
        rows.push_back(begin_row(0, 0, 0, STAT_TRIAL, 0));
        rows.push_back(error_row(48'd2, 1, 0, STAT_TRIAL, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(rows[i].ridx, rows[i].value);
            end else begin
                send_item(rows[i]);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            quiet = (phase == 3);
            write_reg(REG_TOLERANCE, pick(1, {16'd0, STEP_MASK}));
            write_reg(REG_START, pick(1, {16'd0, STEP_MASK}));
            write_reg(REG_SAFETY, pick(0, 64'hFFFF));
            write_reg(REG_FLOOR, pick(0, 64'hFFFFF));
            write_reg(REG_CAP, pick(65536, 64'hFFFFF));
            write_reg(REG_ORDER, $urandom_range(0, 15));
            for (int k = 0; k < 100; ) begin
                if ($urandom_range(0, 6) != 0) begin
                    send_item(begin_row($urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                                        0, STAT_TRIAL, 0));
                    n_err = $urandom_range(1, 4);
                    for (int j = 0; j < n_err; j++)
                        send_item(error_row(rand_error(), j == n_err - 1, 0, STAT_TRIAL, 0));
                    k += n_err + 1;
                end else begin
                    send_item(error_row(rand_error(), $urandom_range(0, 1), 0, STAT_TRIAL, 0));
                    k++;
                end
            end
        end

        drain();
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
